[sv/prefix_function_stream_defines.svh]
// Assertion macros for the prefix function stream RTL
`ifndef PREFIX_FUNCTION_STREAM_DEFINES_SVH
`define PREFIX_FUNCTION_STREAM_DEFINES_SVH

// Property holds at every clock edge outside reset
`define PFS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define PFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[sv/pfs_pkg.sv]
// Types and constants of the prefix function stream
`default_nettype none
package pfs_pkg;
	localparam int SYM_W    = 8;
	localparam int BORDER_W = 12;
	localparam int DATA_W   = 16;
	localparam logic [BORDER_W-1:0] OUT_MAX = 12'hFFF;

	typedef struct packed {
		logic                valid;
		logic [BORDER_W-1:0] border_len;
		logic                too_long;
	} pfs_res_t;
endpackage
`default_nettype wire

[sv/prefix_function_stream.sv]
// Streaming prefix function top level: stores, chain walker and output register
// The first byte of a string or a byte beyond the buffer goes straight to the DONE
//   state; any other byte walks the fallback chain in PROBE before it commits.
// A new byte is taken only once the previous one has committed; the chain walk makes one
//   symbol store and one border store read per cycle, each with a registered read.
// Reset clears position and control; the stores hold no reset and need no clearing pass.
`default_nettype none
module prefix_function_stream import pfs_pkg::*; #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [SYM_W-1:0]  s_tdata,   // [7:0] symbol
	input  wire logic [0:0]        s_tuser,   // [0] start_req
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // [11:0] border_len, [15:12] zero
	output logic [0:0]             m_tuser    // [0] too_long
);
	localparam int AW = $clog2(MAX_LEN);

	pfs_res_t         res;
	logic             out_free;
	logic             sym_wr_en;
	logic [AW-1:0]    sym_wr_addr;
	logic [SYM_W-1:0] sym_wr_data;
	logic [AW-1:0]    sym_rd_addr;
	logic [SYM_W-1:0] sym_rd_data;
	logic             bor_wr_en;
	logic [AW-1:0]    bor_wr_addr;
	logic [AW-1:0]    bor_wr_data;
	logic [AW-1:0]    bor_rd_addr;
	logic [AW-1:0]    bor_rd_data;

	pfs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_sym_ram (
		.clk     (clk),
		.wr_en   (sym_wr_en),
		.wr_addr (sym_wr_addr),
		.wr_data (sym_wr_data),
		.rd_addr (sym_rd_addr),
		.rd_data (sym_rd_data)
	);

	pfs_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_bor_ram (
		.clk     (clk),
		.wr_en   (bor_wr_en),
		.wr_addr (bor_wr_addr),
		.wr_data (bor_wr_data),
		.rd_addr (bor_rd_addr),
		.rd_data (bor_rd_data)
	);

	pfs_engine #(.MAX_LEN(MAX_LEN)) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_symbol   (s_tdata),
		.in_start    (s_tuser[0]),
		.in_ready    (s_tready),
		.out_free    (out_free),
		.res         (res),
		.sym_wr_en   (sym_wr_en),
		.sym_wr_addr (sym_wr_addr),
		.sym_wr_data (sym_wr_data),
		.sym_rd_addr (sym_rd_addr),
		.sym_rd_data (sym_rd_data),
		.bor_wr_en   (bor_wr_en),
		.bor_wr_addr (bor_wr_addr),
		.bor_wr_data (bor_wr_data),
		.bor_rd_addr (bor_rd_addr),
		.bor_rd_data (bor_rd_data)
	);

	pfs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule
`default_nettype wire

[sv/pfs_ram.sv]
// Generic simple dual-port RAM with registered read
`default_nettype none
module pfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

[sv/pfs_engine.sv]
// Fallback chain walker: probes the stores, commits each byte and its border unless the buffer is full
`default_nettype none
`include "prefix_function_stream_defines.svh"
module pfs_engine import pfs_pkg::*; #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [SYM_W-1:0]           in_symbol,
	input  wire logic                       in_start,
	output logic                            in_ready,
	input  wire logic                       out_free,
	output pfs_res_t                        res,
	output logic                            sym_wr_en,
	output logic [$clog2(MAX_LEN)-1:0]      sym_wr_addr,
	output logic [SYM_W-1:0]                sym_wr_data,
	output logic [$clog2(MAX_LEN)-1:0]      sym_rd_addr,
	input  wire logic [SYM_W-1:0]           sym_rd_data,
	output logic                            bor_wr_en,
	output logic [$clog2(MAX_LEN)-1:0]      bor_wr_addr,
	output logic [$clog2(MAX_LEN)-1:0]      bor_wr_data,
	output logic [$clog2(MAX_LEN)-1:0]      bor_rd_addr,
	input  wire logic [$clog2(MAX_LEN)-1:0] bor_rd_data
);
	localparam int AW = $clog2(MAX_LEN);
	localparam int PW = $clog2(MAX_LEN + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]       state_q;
	logic [PW-1:0]    pos_q;
	logic [AW-1:0]    last_k_q;
	logic [AW-1:0]    kd_q;
	logic [AW-1:0]    k_s1;
	logic [SYM_W-1:0] c_q;
	logic             first_q;
	logic             full_q;

	logic             accept;
	logic             is_first;
	logic             is_full;
	logic             match;
	logic             resolved;
	logic [AW-1:0]    k_new;
	logic [AW-1:0]    kc;
	logic [AW-1:0]    rd_k;
	logic             commit;
	logic [AW+11:0]   kc_wide;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_first = in_start || (pos_q == '0);
	assign is_full  = (pos_q == PW'(MAX_LEN));

	assign match    = (sym_rd_data == c_q);
	assign resolved = match || (k_s1 == '0);
	assign k_new    = match ? (k_s1 + AW'(1)) : '0;
	assign kc       = (state_q == ST_PROBE) ? k_new : kd_q;

	assign rd_k        = (state_q == ST_PROBE) ? bor_rd_data : last_k_q;
	assign sym_rd_addr = rd_k;
	assign bor_rd_addr = rd_k - AW'(1);

	assign commit = out_free && (((state_q == ST_PROBE) && resolved) || (state_q == ST_DONE));

	assign sym_wr_en   = commit && !full_q;
	assign bor_wr_en   = commit && !full_q;
	assign sym_wr_addr = first_q ? '0 : pos_q[AW-1:0];
	assign bor_wr_addr = first_q ? '0 : pos_q[AW-1:0];
	assign sym_wr_data = c_q;
	assign bor_wr_data = first_q ? '0 : kc;

	assign kc_wide        = {12'b0, kc};
	assign res.valid      = commit;
	assign res.too_long   = full_q;
	assign res.border_len = (kc_wide > (AW+12)'(OUT_MAX)) ? OUT_MAX : kc_wide[11:0];

	always_ff @(posedge clk) begin
		k_s1 <= rd_k;
		if (accept) begin
			c_q <= in_symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pos_q    <= '0;
			last_k_q <= '0;
			kd_q     <= '0;
			first_q  <= 1'b0;
			full_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_first) begin
							kd_q    <= '0;
							first_q <= 1'b1;
							full_q  <= 1'b0;
							state_q <= ST_DONE;
						end else if (is_full) begin
							kd_q    <= AW'(MAX_LEN - 1);
							first_q <= 1'b0;
							full_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							first_q <= 1'b0;
							full_q  <= 1'b0;
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (resolved) begin
						kd_q    <= k_new;
						state_q <= out_free ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit && !full_q) begin
				if (first_q) begin
					pos_q    <= PW'(1);
					last_k_q <= '0;
				end else begin
					pos_q    <= pos_q + PW'(1);
					last_k_q <= kc;
				end
			end
		end
	end

	`PFS_ASSERT(a_pos_bound, clk, arst_n, pos_q <= PW'(MAX_LEN), "position beyond buffer")
	`PFS_ASSERT(a_probe_written, clk, arst_n, (state_q != ST_PROBE) || (PW'(k_s1) < pos_q), "probe of unwritten entry")
	`PFS_ASSERT_NEXT(a_pos_adv, clk, arst_n, commit && !first_q && !full_q, pos_q == $past(pos_q) + PW'(1), "position did not advance")
	`PFS_ASSERT_NEXT(a_first_pos, clk, arst_n, commit && first_q, pos_q == PW'(1), "new string did not restart position")
endmodule
`default_nettype wire

[sv/pfs_out.sv]
// Output register for result transfers
`default_nettype none
module pfs_out import pfs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pfs_res_t  res,
	output logic           out_free,
	output logic           m_tvalid,
	input  wire logic      m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic [0:0]     m_tuser
);
	logic                valid_q;
	logic [BORDER_W-1:0] border_q;
	logic                too_long_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {(DATA_W-BORDER_W)'(0), border_q};
	assign m_tuser  = too_long_q;

	always_ff @(posedge clk) begin
		if (res.valid) begin
			border_q   <= res.border_len;
			too_long_q <= res.too_long;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire
